[sv/smpt_pkg.sv]
// ----------------------------------------------------------------------------
// smpt_pkg
// Shared types, codes and constants of the shadow map pixel test block.
// ----------------------------------------------------------------------------
package smpt_pkg;

  localparam int unsigned DVD_W     = 49;
  localparam int unsigned DSR_W     = 32;
  localparam int unsigned QUO_W     = 50;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [15:0] BG_LIMIT  = 16'd64880;
  localparam int          CLOSE_TOL = 66;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  localparam logic signed [QUO_W-1:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [QUO_W-1:0] SAT_LO = -50'sd2147483648;

  typedef enum logic [1:0] {
    CMD_LOAD_DEPTH  = 2'd0,
    CMD_LOAD_MATRIX = 2'd1,
    CMD_SHADE       = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_IMAGE_COLS      = 3'd0,
    REG_IMAGE_ROWS      = 3'd1,
    REG_CAM_NEAR        = 3'd2,
    REG_CAM_FAR         = 3'd3,
    REG_LIGHT_NEAR      = 3'd4,
    REG_LIGHT_FAR       = 3'd5,
    REG_SHADOW_STRENGTH = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_DIV_V0,
    OP_DIV_V1,
    OP_STORE_VEC,
    OP_VZ_MUL,
    OP_VZ_SET,
    OP_MAT_MUL,
    OP_MAT_ACC,
    OP_ROW_STORE,
    OP_DIV_W,
    OP_STORE_RES,
    OP_XFER,
    OP_DIV_Z,
    OP_Z_STORE,
    OP_Z_ZERO,
    OP_L_MUL,
    OP_L_SET,
    OP_NB_ADDR,
    OP_NB_CMP,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       mtx;
    logic [1:0] row;
    logic [1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic bg;
    logic w_zero;
    logic span_zero;
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [QUO_W-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return x[31:0];
  endfunction

endpackage

[sv/smpt_ram.sv]
// ----------------------------------------------------------------------------
// smpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smpt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/smpt_div.sv]
// ----------------------------------------------------------------------------
// smpt_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module smpt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [smpt_pkg::QUO_W-1:0] dividend_i,
  input  logic signed [smpt_pkg::DSR_W:0]   divisor_i,
  output logic signed [smpt_pkg::QUO_W-1:0] quotient_o,
  output logic                              done_o
);

  logic [smpt_pkg::DVD_W-1:0]     dvd_q;
  logic [smpt_pkg::DSR_W-1:0]     dsr_q, rem_q;
  logic [smpt_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q, neg_q;

  logic [smpt_pkg::QUO_W-1:0] dvd_abs;
  logic [smpt_pkg::DSR_W:0]   dsr_abs, rem_sh, rem_sub;
  logic                       ge;

  always_comb begin
    dvd_abs = dividend_i[smpt_pkg::QUO_W-1] ? 50'(-dividend_i) : 50'(dividend_i);
    dsr_abs = divisor_i[smpt_pkg::DSR_W] ? 33'(-divisor_i) : 33'(divisor_i);
    rem_sh  = {rem_q, dvd_q[smpt_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= smpt_pkg::DIV_CNT_W'(smpt_pkg::DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == smpt_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_abs[smpt_pkg::DVD_W-1:0];
      dsr_q <= dsr_abs[smpt_pkg::DSR_W-1:0];
      rem_q <= '0;
      neg_q <= dividend_i[smpt_pkg::QUO_W-1] ^ divisor_i[smpt_pkg::DSR_W];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[smpt_pkg::DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[smpt_pkg::DSR_W-1:0] : rem_sh[smpt_pkg::DSR_W-1:0];
    end
  end

  assign quotient_o = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign done_o     = done_q;

endmodule

[sv/smpt_ctrl.sv]
// ----------------------------------------------------------------------------
// smpt_ctrl
// Sequencer for the shade command: steps the datapath through both
// transforms, the divides and the nine-point neighbor compare.
// ----------------------------------------------------------------------------
module smpt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_acc_i,
  input  logic [1:0]         in_cmd_i,
  input  logic               out_stall_i,
  input  smpt_pkg::dp_stat_t stat_i,
  output smpt_pkg::dp_cmd_t  dp_cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_V0_DIV, S_V0_WAIT, S_V1_DIV, S_V1_WAIT, S_VZ_MUL, S_VZ_SET,
    S_M_RD, S_M_MUL, S_M_ACC, S_ROW_ST, S_W_CHECK, S_W_DIV, S_W_WAIT, S_XFER,
    S_Z_CHECK, S_Z_DIV, S_Z_WAIT, S_L_MUL, S_L_SET, S_NB_ADDR, S_NB_RD, S_NB_CMP,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic [1:0] r_q, c_q, k_q;
  logic       mtx_q, out_valid_q;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      mtx_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc_i && in_cmd_i == smpt_pkg::CMD_SHADE) state_q <= S_START;
        end
        S_START:   state_q <= stat_i.bg ? S_FINISH : S_V0_DIV;
        S_V0_DIV:  state_q <= S_V0_WAIT;
        S_V0_WAIT: if (stat_i.div_done) state_q <= S_V1_DIV;
        S_V1_DIV:  state_q <= S_V1_WAIT;
        S_V1_WAIT: if (stat_i.div_done) state_q <= S_VZ_MUL;
        S_VZ_MUL:  state_q <= S_VZ_SET;
        S_VZ_SET: begin
          mtx_q   <= 1'b0;
          r_q     <= '0;
          c_q     <= '0;
          state_q <= S_M_RD;
        end
        S_M_RD:  state_q <= S_M_MUL;
        S_M_MUL: state_q <= S_M_ACC;
        S_M_ACC: begin
          c_q <= c_q + 1'b1;
          state_q <= (c_q == 2'd3) ? S_ROW_ST : S_M_RD;
        end
        S_ROW_ST: begin
          k_q <= '0;
          r_q <= r_q + 1'b1;
          state_q <= (r_q == 2'd3) ? S_W_CHECK : S_M_RD;
        end
        S_W_CHECK: begin
          if (stat_i.w_zero) state_q <= mtx_q ? S_Z_CHECK : S_XFER;
          else state_q <= S_W_DIV;
        end
        S_W_DIV: state_q <= S_W_WAIT;
        S_W_WAIT: begin
          if (stat_i.div_done) begin
            k_q <= k_q + 1'b1;
            if (k_q == 2'd2) state_q <= mtx_q ? S_Z_CHECK : S_XFER;
            else state_q <= S_W_DIV;
          end
        end
        S_XFER: begin
          mtx_q   <= 1'b1;
          r_q     <= '0;
          c_q     <= '0;
          state_q <= S_M_RD;
        end
        S_Z_CHECK: begin
          k_q     <= '0;
          state_q <= stat_i.span_zero ? S_L_MUL : S_Z_DIV;
        end
        S_Z_DIV:  state_q <= S_Z_WAIT;
        S_Z_WAIT: if (stat_i.div_done) state_q <= S_L_MUL;
        S_L_MUL:  state_q <= S_L_SET;
        S_L_SET: begin
          k_q <= k_q + 1'b1;
          r_q <= '0;
          c_q <= '0;
          state_q <= (k_q == 2'd1) ? S_NB_ADDR : S_L_MUL;
        end
        S_NB_ADDR: state_q <= S_NB_RD;
        S_NB_RD:   state_q <= S_NB_CMP;
        S_NB_CMP: begin
          if (c_q == 2'd2) begin
            c_q <= '0;
            r_q <= r_q + 1'b1;
            state_q <= (r_q == 2'd2) ? S_FINISH : S_NB_ADDR;
          end else begin
            c_q <= c_q + 1'b1;
            state_q <= S_NB_ADDR;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    dp_cmd_o     = '{op: smpt_pkg::OP_NOP, mtx: mtx_q, row: r_q, col: c_q};
    case (state_q)
      S_V0_DIV: dp_cmd_o.op = smpt_pkg::OP_DIV_V0;
      S_V0_WAIT: begin
        dp_cmd_o.row = 2'd0;
        if (stat_i.div_done) dp_cmd_o.op = smpt_pkg::OP_STORE_VEC;
      end
      S_V1_DIV: dp_cmd_o.op = smpt_pkg::OP_DIV_V1;
      S_V1_WAIT: begin
        dp_cmd_o.row = 2'd1;
        if (stat_i.div_done) dp_cmd_o.op = smpt_pkg::OP_STORE_VEC;
      end
      S_VZ_MUL: dp_cmd_o.op = smpt_pkg::OP_VZ_MUL;
      S_VZ_SET: dp_cmd_o.op = smpt_pkg::OP_VZ_SET;
      S_M_MUL:  dp_cmd_o.op = smpt_pkg::OP_MAT_MUL;
      S_M_ACC:  dp_cmd_o.op = smpt_pkg::OP_MAT_ACC;
      S_ROW_ST: dp_cmd_o.op = smpt_pkg::OP_ROW_STORE;
      S_W_DIV: begin
        dp_cmd_o.row = k_q;
        dp_cmd_o.op  = smpt_pkg::OP_DIV_W;
      end
      S_W_WAIT: begin
        dp_cmd_o.row = k_q;
        if (stat_i.div_done) dp_cmd_o.op = smpt_pkg::OP_STORE_RES;
      end
      S_XFER: dp_cmd_o.op = smpt_pkg::OP_XFER;
      S_Z_CHECK: begin
        if (stat_i.span_zero) dp_cmd_o.op = smpt_pkg::OP_Z_ZERO;
      end
      S_Z_DIV: dp_cmd_o.op = smpt_pkg::OP_DIV_Z;
      S_Z_WAIT: begin
        if (stat_i.div_done) dp_cmd_o.op = smpt_pkg::OP_Z_STORE;
      end
      S_L_MUL: begin
        dp_cmd_o.row = k_q;
        dp_cmd_o.op  = smpt_pkg::OP_L_MUL;
      end
      S_L_SET: begin
        dp_cmd_o.row = k_q;
        dp_cmd_o.op  = smpt_pkg::OP_L_SET;
      end
      S_NB_ADDR: dp_cmd_o.op = smpt_pkg::OP_NB_ADDR;
      S_NB_CMP:  dp_cmd_o.op = smpt_pkg::OP_NB_CMP;
      S_FINISH: begin
        if (out_free) dp_cmd_o.op = smpt_pkg::OP_FINISH;
      end
      default: dp_cmd_o.op = smpt_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_V0_WAIT || state_q == S_V1_WAIT ||
                         state_q == S_W_WAIT || state_q == S_Z_WAIT))
    else $error("divider finished outside a wait state");

  a_shade_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc_i && in_cmd_i == smpt_pkg::CMD_SHADE) |=> state_q == S_START)
    else $error("shade beat did not start the sequence");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && out_stall_i) |=>
      (state_q == S_FINISH && out_valid_q))
    else $error("result overwritten while output stalled");
`endif

endmodule

[sv/smpt_dpath.sv]
// ----------------------------------------------------------------------------
// smpt_dpath
// Datapath: stores, shared multiplier, divider, vector registers and the
// neighbor compare, driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module smpt_dpath #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_acc_i,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        load_addr_i,
  input  logic signed [31:0] load_value_i,
  input  logic [7:0]         pixel_col_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [15:0]        pixel_depth_i,
  input  logic [7:0]         in_red_i,
  input  logic [7:0]         in_green_i,
  input  logic [7:0]         in_blue_i,
  input  logic [8:0]         image_cols_i,
  input  logic [8:0]         image_rows_i,
  input  logic [30:0]        cam_near_i,
  input  logic [30:0]        cam_far_i,
  input  logic [30:0]        light_near_i,
  input  logic [30:0]        light_far_i,
  input  logic [8:0]         shadow_strength_i,
  input  smpt_pkg::dp_cmd_t  dp_cmd_i,
  output smpt_pkg::dp_stat_t stat_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               in_shadow_o,
  output logic               is_background_o
);

  logic [7:0]  col_q, row_q, red_q, green_q, blue_q;
  logic [15:0] depth_q;
  logic signed [31:0] vec_q [4];
  logic signed [31:0] res_q [4];
  logic signed [49:0] acc_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] z_q;
  logic signed [25:0] dc_q, dr_q;
  logic [15:0] addr_q;
  logic        inb_q, close_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q;
  logic        in_shadow_q, is_background_q;

  logic [8:0]  cs, rs;
  logic [31:0] mat_rdata;
  logic [15:0] dep_rdata;
  logic        mat_we, dep_we;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p, p_b16, p_b17;
  logic signed [49:0] t16, vz_sum;
  logic signed [48:0] t17;

  logic               div_start, div_done;
  logic signed [49:0] div_dvd, div_quo;
  logic signed [32:0] div_dsr, span;
  logic signed [10:0] v0n, v1n;
  logic signed [32:0] zn;

  logic signed [26:0] nb_m, nb_n;
  logic [17:0]        nb_lin;
  logic               nb_inb, nb_hit;
  logic signed [33:0] z_ext, nb_lim;

  logic [8:0]  keep;
  logic        shadow;
  logic [16:0] sc_r, sc_g, sc_b;

  always_comb begin
    if (image_cols_i == 9'd0) cs = 9'd1;
    else if (int'(image_cols_i) > MAX_COLS) cs = 9'(MAX_COLS);
    else cs = image_cols_i;
    if (image_rows_i == 9'd0) rs = 9'd1;
    else if (int'(image_rows_i) > MAX_ROWS) rs = 9'(MAX_ROWS);
    else rs = image_rows_i;
  end

  assign mat_we = in_acc_i && cmd_i == smpt_pkg::CMD_LOAD_MATRIX &&
                  load_addr_i[15:5] == 11'd0;
  assign dep_we = in_acc_i && cmd_i == smpt_pkg::CMD_LOAD_DEPTH;

  smpt_ram #(.WIDTH(32), .DEPTH(32)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (load_addr_i[4:0]),
    .wdata_i (load_value_i),
    .raddr_i ({dp_cmd_i.mtx, dp_cmd_i.row, dp_cmd_i.col}),
    .rdata_o (mat_rdata)
  );

  smpt_ram #(.WIDTH(16), .DEPTH(65536)) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (load_addr_i),
    .wdata_i (load_value_i[15:0]),
    .raddr_i (addr_q),
    .rdata_o (dep_rdata)
  );

  // shared multiplier
  always_comb begin
    case (dp_cmd_i.op)
      smpt_pkg::OP_VZ_MUL: begin
        mul_a = $signed({17'b0, depth_q});
        mul_b = $signed({2'b0, cam_far_i}) - $signed({2'b0, cam_near_i});
      end
      smpt_pkg::OP_MAT_MUL: begin
        mul_a = $signed({mat_rdata[31], mat_rdata});
        mul_b = 33'(vec_q[dp_cmd_i.col]);
      end
      smpt_pkg::OP_L_MUL: begin
        mul_a = 33'(res_q[dp_cmd_i.row]) + 33'sd65536;
        mul_b = $signed({24'b0, (dp_cmd_i.row == 2'd0) ? cs : rs});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  // truncation toward zero after the fixed-point shift
  assign p_b16  = prod_q + $signed({50'b0, {16{prod_q[65]}}});
  assign p_b17  = prod_q + $signed({49'b0, {17{prod_q[65]}}});
  assign t16    = p_b16[65:16];
  assign t17    = p_b17[65:17];
  assign vz_sum = t16 + $signed({19'b0, cam_near_i});

  // divider operands
  assign v0n  = $signed({2'b0, col_q, 1'b0}) - $signed({2'b0, cs});
  assign v1n  = $signed({2'b0, row_q, 1'b0}) - $signed({2'b0, rs});
  assign zn   = 33'(res_q[2]) - $signed({2'b0, light_near_i});
  assign span = $signed({2'b0, light_far_i}) - $signed({2'b0, light_near_i});

  always_comb begin
    div_start = 1'b1;
    case (dp_cmd_i.op)
      smpt_pkg::OP_DIV_V0: begin
        div_dvd = $signed({{23{v0n[10]}}, v0n, 16'b0});
        div_dsr = $signed({24'b0, cs});
      end
      smpt_pkg::OP_DIV_V1: begin
        div_dvd = $signed({{23{v1n[10]}}, v1n, 16'b0});
        div_dsr = $signed({24'b0, rs});
      end
      smpt_pkg::OP_DIV_W: begin
        div_dvd = $signed({{2{res_q[dp_cmd_i.row][31]}}, res_q[dp_cmd_i.row], 16'b0});
        div_dsr = 33'(res_q[3]);
      end
      smpt_pkg::OP_DIV_Z: begin
        div_dvd = $signed({zn[32], zn, 16'b0});
        div_dsr = span;
      end
      default: begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = '0;
      end
    endcase
  end

  smpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // neighbor address and compare
  always_comb begin
    nb_m   = 27'(dc_q) + 27'(dp_cmd_i.col) - 27'sd1;
    nb_n   = 27'(dr_q) + 27'(dp_cmd_i.row) - 27'sd1;
    nb_inb = !nb_m[26] && (nb_m < $signed({18'b0, cs})) &&
             !nb_n[26] && (nb_n < $signed({18'b0, rs}));
    nb_lin = 18'(nb_n[8:0]) * 18'(cs) + 18'(nb_m[8:0]);
    z_ext  = 34'(z_q);
    nb_lim = $signed({18'b0, dep_rdata}) + 34'(smpt_pkg::CLOSE_TOL);
    nb_hit = z_ext < nb_lim;
  end

  // output color
  always_comb begin
    keep   = (shadow_strength_i > 9'd256) ? 9'd0 : 9'(9'd256 - shadow_strength_i);
    shadow = !(depth_q > smpt_pkg::BG_LIMIT) && !close_q;
    sc_r   = red_q * keep;
    sc_g   = green_q * keep;
    sc_b   = blue_q * keep;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      col_q   <= pixel_col_i;
      row_q   <= pixel_row_i;
      depth_q <= pixel_depth_i;
      red_q   <= in_red_i;
      green_q <= in_green_i;
      blue_q  <= in_blue_i;
    end
    case (dp_cmd_i.op)
      smpt_pkg::OP_DIV_V0:    close_q <= 1'b0;
      smpt_pkg::OP_STORE_VEC: vec_q[dp_cmd_i.row] <= smpt_pkg::sat32(div_quo);
      smpt_pkg::OP_VZ_MUL:    prod_q <= mul_p;
      smpt_pkg::OP_VZ_SET: begin
        vec_q[2] <= smpt_pkg::sat32(vz_sum);
        vec_q[3] <= smpt_pkg::Q_ONE;
        acc_q    <= '0;
      end
      smpt_pkg::OP_MAT_MUL: prod_q <= mul_p;
      smpt_pkg::OP_MAT_ACC: acc_q <= acc_q + t16;
      smpt_pkg::OP_ROW_STORE: begin
        res_q[dp_cmd_i.row] <= smpt_pkg::sat32(acc_q);
        acc_q <= '0;
      end
      smpt_pkg::OP_STORE_RES: res_q[dp_cmd_i.row] <= smpt_pkg::sat32(div_quo);
      smpt_pkg::OP_XFER: begin
        vec_q[0] <= res_q[0];
        vec_q[1] <= res_q[1];
        vec_q[2] <= res_q[2];
        vec_q[3] <= smpt_pkg::Q_ONE;
        acc_q    <= '0;
      end
      smpt_pkg::OP_Z_STORE: z_q <= smpt_pkg::sat32(div_quo);
      smpt_pkg::OP_Z_ZERO:  z_q <= '0;
      smpt_pkg::OP_L_MUL:   prod_q <= mul_p;
      smpt_pkg::OP_L_SET: begin
        if (dp_cmd_i.row == 2'd0) dc_q <= t17[25:0];
        else dr_q <= t17[25:0];
      end
      smpt_pkg::OP_NB_ADDR: begin
        addr_q <= nb_lin[15:0];
        inb_q  <= nb_inb;
      end
      smpt_pkg::OP_NB_CMP: begin
        if (inb_q && nb_hit) close_q <= 1'b1;
      end
      smpt_pkg::OP_FINISH: begin
        out_red_q       <= shadow ? sc_r[15:8] : red_q;
        out_green_q     <= shadow ? sc_g[15:8] : green_q;
        out_blue_q      <= shadow ? sc_b[15:8] : blue_q;
        in_shadow_q     <= shadow;
        is_background_q <= depth_q > smpt_pkg::BG_LIMIT;
      end
      default: ;
    endcase
  end

  assign stat_o = '{bg:        depth_q > smpt_pkg::BG_LIMIT,
                    w_zero:    res_q[3] == 32'sd0,
                    span_zero: light_far_i == light_near_i,
                    div_done:  div_done};

  assign out_red_o       = out_red_q;
  assign out_green_o     = out_green_q;
  assign out_blue_o      = out_blue_q;
  assign in_shadow_o     = in_shadow_q;
  assign is_background_o = is_background_q;

endmodule

[sv/shadow_map_pixel_test.sv]
// ----------------------------------------------------------------------------
// shadow_map_pixel_test
// Per-pixel hard shadow test against a light depth map.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one command per beat:
//  load a light depth word, load a matrix entry, or shade a pixel. Loads are
//  written in the beat's cycle and give no result. A shade beat gives one
//  result beat on the output channel (out_valid_o / out_stall_i).
//  The work of a shade beat is dominated by the bit-serial divider
//  (49 steps per divide, up to nine divides), plus two matrix
//  transforms through the shared multiplier and nine depth reads.
//  Background pixels and zero w divisors shorten this; a background pixel
//  skips it all. One shade command is in work at a time; loads are
//  accepted only while no shade command is in work.
//  A finished result waits in the output register while the receiver
//  stalls; the next command is still accepted, but the following result
//  waits until the register is free.
//  Reset clears control and loads the register defaults; the depth and
//  matrix stores hold nothing valid until loaded. The user writes registers
//  through cfg_we_i only while the block is idle; the block has no such check.
// ----------------------------------------------------------------------------
module shadow_map_pixel_test #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        load_addr_i,
  input  logic signed [31:0] load_value_i,
  input  logic [7:0]         pixel_col_i,
  input  logic [7:0]         pixel_row_i,
  input  logic [15:0]        pixel_depth_i,
  input  logic [7:0]         in_red_i,
  input  logic [7:0]         in_green_i,
  input  logic [7:0]         in_blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic               in_shadow_o,
  output logic               is_background_o
);

  logic [8:0]  image_cols_q, image_rows_q, shadow_strength_q;
  logic [30:0] cam_near_q, cam_far_q, light_near_q, light_far_q;
  logic        in_acc;

  smpt_pkg::dp_cmd_t  dp_cmd;
  smpt_pkg::dp_stat_t dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_cols_q      <= 9'd256;
      image_rows_q      <= 9'd256;
      cam_near_q        <= 31'd65536;
      cam_far_q         <= 31'd6553600;
      light_near_q      <= 31'd65536;
      light_far_q       <= 31'd6553600;
      shadow_strength_q <= 9'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        smpt_pkg::REG_IMAGE_COLS:      image_cols_q      <= cfg_data_i[8:0];
        smpt_pkg::REG_IMAGE_ROWS:      image_rows_q      <= cfg_data_i[8:0];
        smpt_pkg::REG_CAM_NEAR:        cam_near_q        <= cfg_data_i;
        smpt_pkg::REG_CAM_FAR:         cam_far_q         <= cfg_data_i;
        smpt_pkg::REG_LIGHT_NEAR:      light_near_q      <= cfg_data_i;
        smpt_pkg::REG_LIGHT_FAR:       light_far_q       <= cfg_data_i;
        smpt_pkg::REG_SHADOW_STRENGTH: shadow_strength_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;

  smpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .in_cmd_i    (cmd_i),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .dp_cmd_o    (dp_cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  smpt_dpath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_acc_i          (in_acc),
    .cmd_i             (cmd_i),
    .load_addr_i       (load_addr_i),
    .load_value_i      (load_value_i),
    .pixel_col_i       (pixel_col_i),
    .pixel_row_i       (pixel_row_i),
    .pixel_depth_i     (pixel_depth_i),
    .in_red_i          (in_red_i),
    .in_green_i        (in_green_i),
    .in_blue_i         (in_blue_i),
    .image_cols_i      (image_cols_q),
    .image_rows_i      (image_rows_q),
    .cam_near_i        (cam_near_q),
    .cam_far_i         (cam_far_q),
    .light_near_i      (light_near_q),
    .light_far_i       (light_far_q),
    .shadow_strength_i (shadow_strength_q),
    .dp_cmd_i          (dp_cmd),
    .stat_o            (dp_stat),
    .out_red_o         (out_red_o),
    .out_green_o       (out_green_o),
    .out_blue_o        (out_blue_o),
    .in_shadow_o       (in_shadow_o),
    .is_background_o   (is_background_o)
  );

endmodule

[verif/shadow_map_pixel_test_chk.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shadow_map_pixel_test_chk
// Watches the register port and both channels of the shadow map pixel test
// block, keeps its own copy of the depth store, the matrices and the
// registers, works out the shaded pixel for each shade beat and compares
// every result beat with the oldest outstanding pixel.
// ----------------------------------------------------------------------------
module shadow_map_pixel_test_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] load_addr_i,
  input  logic [31:0] load_value_i,
  input  logic [7:0]  pixel_col_i,
  input  logic [7:0]  pixel_row_i,
  input  logic [15:0] pixel_depth_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_red_i,
  input  logic [7:0]  out_green_i,
  input  logic [7:0]  out_blue_i,
  input  logic        in_shadow_i,
  input  logic        is_background_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint ONE = 65536;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       shadow;
    logic       bg;
  } pixel_t;

  typedef longint vec4_t [4];

  logic [8:0]  cols_q, rows_q, strength_q;
  logic [30:0] cam_near_q, cam_far_q, light_near_q, light_far_q;
  logic [15:0] depth_mem [65536];
  logic [31:0] mat_mem [32];
  pixel_t      pixel_q[$];

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic vec4_t mat_apply(input int base, input vec4_t v);
    vec4_t  o;
    longint acc;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        acc += (longint'($signed(mat_mem[base + r*4 + c])) * v[c]) / ONE;
      end
      o[r] = clip32(acc);
    end
    return o;
  endfunction

  function automatic vec4_t w_divide(input vec4_t v);
    vec4_t o;
    o = v;
    if (v[3] != 0) begin
      for (int k = 0; k < 3; k++) o[k] = clip32((v[k] * ONE) / v[3]);
    end
    return o;
  endfunction

  function automatic pixel_t shade_pixel(input logic [7:0] col, input logic [7:0] row,
                                         input logic [15:0] depth, input logic [7:0] red,
                                         input logic [7:0] green, input logic [7:0] blue);
    pixel_t  p;
    longint  cs, rs, dc, dr, span, z, s;
    vec4_t   v, w, l;
    logic    close;
    logic [15:0] idx;
    p.red = red;
    p.green = green;
    p.blue = blue;
    p.bg = depth > smpt_pkg::BG_LIMIT;
    p.shadow = 1'b0;
    if (!p.bg) begin
      cs = (cols_q < 1) ? 1 : (cols_q > 256) ? 256 : longint'(cols_q);
      rs = (rows_q < 1) ? 1 : (rows_q > 256) ? 256 : longint'(rows_q);
      v[0] = ((2 * longint'(col) - cs) * ONE) / cs;
      v[1] = ((2 * longint'(row) - rs) * ONE) / rs;
      v[2] = clip32((longint'(depth) * (longint'(cam_far_q) - longint'(cam_near_q))) / ONE
                    + longint'(cam_near_q));
      v[3] = ONE;
      w = w_divide(mat_apply(0, v));
      w[3] = ONE;
      l = w_divide(mat_apply(16, w));
      dc = ((l[0] + ONE) * cs) / (2 * ONE);
      dr = ((l[1] + ONE) * rs) / (2 * ONE);
      span = longint'(light_far_q) - longint'(light_near_q);
      z = 0;
      if (span != 0) z = clip32(((l[2] - longint'(light_near_q)) * ONE) / span);
      close = 1'b0;
      for (longint m = dc - 1; m <= dc + 1; m++) begin
        for (longint n = dr - 1; n <= dr + 1; n++) begin
          if (m >= 0 && m < cs && n >= 0 && n < rs) begin
            idx = 16'(n * cs + m);
            if (z < longint'(depth_mem[idx]) + smpt_pkg::CLOSE_TOL) close = 1'b1;
          end
        end
      end
      p.shadow = !close;
    end
    if (p.shadow) begin
      s = (strength_q > 256) ? 256 : longint'(strength_q);
      p.red   = 8'((longint'(red) * (256 - s)) >> 8);
      p.green = 8'((longint'(green) * (256 - s)) >> 8);
      p.blue  = 8'((longint'(blue) * (256 - s)) >> 8);
    end
    return p;
  endfunction

  assign pending_o = pixel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t exp_p;
    if (!rst_ni) begin
      cols_q <= 9'd256;
      rows_q <= 9'd256;
      cam_near_q <= 31'd65536;
      cam_far_q <= 31'd6553600;
      light_near_q <= 31'd65536;
      light_far_q <= 31'd6553600;
      strength_q <= 9'd128;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          smpt_pkg::REG_IMAGE_COLS:      cols_q <= cfg_data_i[8:0];
          smpt_pkg::REG_IMAGE_ROWS:      rows_q <= cfg_data_i[8:0];
          smpt_pkg::REG_CAM_NEAR:        cam_near_q <= cfg_data_i;
          smpt_pkg::REG_CAM_FAR:         cam_far_q <= cfg_data_i;
          smpt_pkg::REG_LIGHT_NEAR:      light_near_q <= cfg_data_i;
          smpt_pkg::REG_LIGHT_FAR:       light_far_q <= cfg_data_i;
          smpt_pkg::REG_SHADOW_STRENGTH: strength_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          smpt_pkg::CMD_LOAD_DEPTH:  depth_mem[load_addr_i] = load_value_i[15:0];
          smpt_pkg::CMD_LOAD_MATRIX: begin
            if (load_addr_i < 16'd32) mat_mem[load_addr_i[4:0]] = load_value_i;
          end
          smpt_pkg::CMD_SHADE: begin
            pixel_q.push_back(shade_pixel(pixel_col_i, pixel_row_i, pixel_depth_i,
                                          in_red_i, in_green_i, in_blue_i));
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          if (fail_count_o < 10) $display("%0t: result beat with no shade pending", $time);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_p = pixel_q.pop_front();
          if (out_red_i !== exp_p.red || out_green_i !== exp_p.green ||
              out_blue_i !== exp_p.blue || in_shadow_i !== exp_p.shadow ||
              is_background_i !== exp_p.bg) begin
            if (fail_count_o < 10)
              $display("%0t: pixel mismatch exp rgb %0d %0d %0d sh %0d bg %0d,",
                       $time, exp_p.red, exp_p.green, exp_p.blue, exp_p.shadow,
                       exp_p.bg, " got %0d %0d %0d sh %0d bg %0d",
                       out_red_i, out_green_i, out_blue_i, in_shadow_i,
                       is_background_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[verif/shadow_map_pixel_test_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shadow_map_pixel_test_tb
// Stimulus for the shadow map pixel test block: fills the depth store and
// matrices, runs directed corner pixels and then random command streams over
// several register settings with random idling on both channels. A checker
// beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module shadow_map_pixel_test_tb;

  localparam int DRAIN_WAIT = 700;
  localparam int WATCH_LIMIT = 6000;
  localparam int FILL_WORDS = 256;
  localparam int RAND_ITEMS = 165;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = '0;
  logic [15:0] load_addr = '0;
  logic signed [31:0] load_value = '0;
  logic [7:0] pix_col = '0, pix_row = '0;
  logic [15:0] pix_depth = '0;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic in_shadow, is_background;
  int fail_count, pending;
  logic quiet = 1'b1;
  int idle_ctr = 0;
  int shade_sent = 0, cmd_sent = 0, phases = 0;

  always #5 clk_i = ~clk_i;

  shadow_map_pixel_test dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cmd_i(cmd),
    .load_addr_i(load_addr), .load_value_i(load_value),
    .pixel_col_i(pix_col), .pixel_row_i(pix_row), .pixel_depth_i(pix_depth),
    .in_red_i(red), .in_green_i(green), .in_blue_i(blue),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_red_o(out_red), .out_green_o(out_green), .out_blue_o(out_blue),
    .in_shadow_o(in_shadow), .is_background_o(is_background)
  );

  shadow_map_pixel_test_chk chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cmd_i(cmd),
    .load_addr_i(load_addr), .load_value_i(load_value),
    .pixel_col_i(pix_col), .pixel_row_i(pix_row), .pixel_depth_i(pix_depth),
    .in_red_i(red), .in_green_i(green), .in_blue_i(blue),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_red_i(out_red), .out_green_i(out_green), .out_blue_i(out_blue),
    .in_shadow_i(in_shadow), .is_background_i(is_background),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall <= 1'b0;
      idle_ctr <= 0;
    end else if (idle_ctr > 0) begin
      idle_ctr <= idle_ctr - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      idle_ctr <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
      idle_ctr <= $urandom_range(0, 30);
    end
  end

  // watchdog on cycles without any beat
  int still_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) still_cycles <= 0;
    else still_cycles <= still_cycles + 1;
    if (still_cycles > WATCH_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] c, input logic [15:0] a, input logic [31:0] v,
                           input logic [7:0] pc, input logic [7:0] pr, input logic [15:0] pd,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c;
    load_addr <= a;
    load_value <= v;
    pix_col <= pc;
    pix_row <= pr;
    pix_depth <= pd;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    cmd_sent++;
    if (c == smpt_pkg::CMD_SHADE) shade_sent++;
  endtask

  task automatic shade(input logic [7:0] pc, input logic [7:0] pr, input logic [15:0] pd,
                       input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_beat(smpt_pkg::CMD_SHADE, 16'($urandom), 32'($urandom), pc, pr, pd, r, g, b);
  endtask

  task automatic load_mat(input logic [15:0] a, input logic [31:0] v);
    send_beat(smpt_pkg::CMD_LOAD_MATRIX, a, v, 8'($urandom), 8'($urandom), 16'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic load_depth(input logic [15:0] a, input logic [31:0] v);
    send_beat(smpt_pkg::CMD_LOAD_DEPTH, a, v, 8'($urandom), 8'($urandom), 16'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [31:0] near_ident(input int k);
    if (k % 5 == 0) return 32'(65536 + $signed($urandom_range(0, 8192)) - 4096);
    return 32'($signed($urandom_range(0, 4096)) - 2048);
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [30:0] v [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  task automatic random_item();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      shade(8'($urandom), 8'($urandom), $urandom_range(0, 2) == 0 ? 16'($urandom) :
            16'($urandom_range(0, 4000)), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (sel < 75) begin
      load_depth(16'($urandom), 32'($urandom));
    end else if (sel < 88) begin
      k = $urandom_range(0, 31);
      load_mat(16'(k), $urandom_range(0, 3) == 0 ? 32'($urandom) : near_ident(k % 16));
    end else if (sel < 95) begin
      load_mat(16'($urandom), 32'($urandom));
    end else begin
      send_beat(CMD_UNUSED, 16'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [30:0] regs [7];
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // images stay within the filled part of the depth store
    regs = '{31'd16, 31'd16, 31'd65536, 31'd6553600, 31'd65536, 31'd6553600, 31'd128};
    write_regs(regs);
    for (int i = 0; i < FILL_WORDS; i++)
      load_depth(16'(i), $urandom_range(0, 3) == 0 ? 32'($urandom) :
                 32'($urandom_range(0, 2000)));
    for (int i = 0; i < 32; i++) load_mat(16'(i), (i % 5 == 0) ? 32'd65536 : 32'd0);

    // directed corners
    shade(8'd0, 8'd0, 16'd0, 8'd255, 8'd255, 8'd255);
    shade(8'd255, 8'd255, 16'd64880, 8'd255, 8'd0, 8'd255);
    shade(8'd128, 8'd128, 16'd64881, 8'd12, 8'd34, 8'd56);
    shade(8'd10, 8'd200, 16'd65535, 8'd255, 8'd255, 8'd255);
    shade(8'd100, 8'd50, 16'd30000, 8'd0, 8'd0, 8'd0);
    shade(8'd200, 8'd20, 16'd1000, 8'd200, 8'd100, 8'd50);
    load_mat(16'd32, 32'hFFFF_FFFF);
    load_mat(16'hFFFF, 32'h8000_0000);
    send_beat(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 16'hFFFF, 8'd255,
              8'd255, 8'd255);
    // zero w in both transforms
    for (int i = 12; i < 16; i++) load_mat(16'(i), 32'd0);
    for (int i = 28; i < 32; i++) load_mat(16'(i), 32'd0);
    shade(8'd60, 8'd70, 16'd20000, 8'd90, 8'd91, 8'd92);
    shade(8'd255, 8'd0, 16'd500, 8'd1, 8'd2, 8'd3);
    load_mat(16'd15, 32'd65536);
    load_mat(16'd31, 32'd65536);
    load_mat(16'd2, 32'h7FFF_FFFF);
    shade(8'd5, 8'd250, 16'd40000, 8'd128, 8'd128, 8'd128);
    load_mat(16'd2, 32'd0);

    quiet = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: regs = '{31'd1, 31'd1, 31'd0, 31'h7FFF_FFFF, 31'd5, 31'd5, 31'd256};
        1: regs = '{31'd0, 31'd511, 31'h7FFF_FFFF, 31'd0, 31'd0, 31'h7FFF_FFFF, 31'd0};
        2: regs = '{31'd300, 31'd1, 31'd65536, 31'd6553600, 31'd65536, 31'd6553600,
                    31'd511};
        3: regs = '{31'($urandom_range(1, 16)), 31'($urandom_range(1, 16)),
                    31'($urandom_range(0, 131072)), 31'($urandom_range(65536, 20000000)),
                    31'($urandom_range(0, 131072)), 31'($urandom_range(65536, 20000000)),
                    31'($urandom_range(0, 256))};
        4: regs = '{31'd16, 31'd16, 31'd65536, 31'd6553600, 31'd65536, 31'd6553600,
                    31'd128};
        default: regs = '{31'd32, 31'd8, 31'd65536, 31'd6553600, 31'd65536, 31'd6553600,
                          31'd200};
      endcase
      write_regs(regs);
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) random_item();
    end

    drain();
    $display("sent %0d commands after the depth fill, %0d of them shade beats,",
             cmd_sent - FILL_WORDS, shade_sent);
    $display("over %0d register settings with idling on both channels", phases);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
